@@ rtl/m4inv_pkg.sv @@
// Shared types and constants of the 4x4 matrix inverse block.
`default_nettype none

package m4inv_pkg;

  // Position of the last element of a matrix, in column-major order.
  localparam logic [3:0] LAST_POS = 4'd15;

  // Datapath operation issued by the controller in one cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LD_A,
    OP_LD_B,
    OP_LD_C3,
    OP_CHAIN,
    OP_COF_CLR,
    OP_COF_ACC,
    OP_DET_CLR,
    OP_DET_LD,
    OP_DET_ACC,
    OP_DEN,
    OP_NUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RES,
    OP_RES_SING
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       elem_we;
    logic [3:0] elem_waddr;
    logic [3:0] elem_raddr;
    logic       cof_we;
    logic [3:0] cof_addr;
    logic       mul_en;
    logic [1:0] mul_limb;
    logic       mul_top;
    logic       term_neg;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/m4inv_stream_if.sv @@
// Valid/ready stream interfaces for the element input and the result output.
`default_nettype none

interface m4inv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface m4inv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [3:0]         result_index;
  logic               singular;
  logic               last;

  modport source (output valid, output result_value, output result_index,
                  output singular, output last, input ready);
  modport sink   (input valid, input result_value, input result_index,
                  input singular, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/m4inv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module m4inv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/m4inv_ctrl.sv @@
// Controller state machine that sequences loading, cofactors, determinant and division.
`default_nettype none

module m4inv_ctrl #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  m4inv_pkg::dp_status_t  status,
  output m4inv_pkg::dp_cmd_t     cmd
);

  import m4inv_pkg::*;

  localparam int DCW = $clog2(ELEM_WIDTH);

  // Sign of each of the six permutation terms of a 3x3 determinant.
  localparam logic [5:0] TERM_NEG = 6'b100110;

  typedef enum logic [4:0] {
    S_LOAD, S_RD0, S_RD1, S_RD2, S_M1, S_M1W, S_CH, S_M2A, S_M2B, S_M2W,
    S_TACC, S_CEND, S_DLD, S_DM, S_DW, S_DACC, S_DEN, S_QRD, S_QNUM,
    S_QINIT, S_QSTEP, S_QRES, S_OUT
  } state_t;

  state_t         state_r, state_nxt;
  logic [3:0]     cof_r, cof_nxt;
  logic [2:0]     term_r, term_nxt;
  logic [1:0]     limb_r, limb_nxt;
  logic [3:0]     load_r, load_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;

  // k-th index of {0,1,2,3} with x removed.
  function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] x);
    return (k < x) ? k : k + 2'd1;
  endfunction

  // Column slot taken by factor f in permutation term t.
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] f);
    logic [5:0] p;
    unique case (t)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd1, 2'd2, 2'd0};
      3'd2:    p = {2'd2, 2'd0, 2'd1};
      3'd3:    p = {2'd0, 2'd2, 2'd1};
      3'd4:    p = {2'd1, 2'd0, 2'd2};
      3'd5:    p = {2'd0, 2'd1, 2'd2};
      default: p = '0;
    endcase
    return p[{f, 1'b0} +: 2];
  endfunction

  // Store position of factor f of term t of cofactor i.
  function automatic logic [3:0] factor_pos(input logic [3:0] i, input logic [2:0] t,
                                            input logic [1:0] f);
    logic [1:0] row;
    logic [1:0] col;
    row = skip_idx(f, i[3:2]);
    col = skip_idx(perm_col(t, f), i[1:0]);
    return {col, row};
  endfunction

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cof_nxt   = cof_r;
    term_nxt  = term_r;
    limb_nxt  = limb_r;
    load_nxt  = load_r;
    dcnt_nxt  = dcnt_r;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.cof_addr = cof_r;
    cmd.elem_waddr = load_r;
    cmd.term_neg = TERM_NEG[term_r] ^ cof_r[0] ^ cof_r[2];

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.elem_we = 1'b1;
          load_nxt    = load_r + 4'd1;
          if (load_r == LAST_POS) begin
            cmd.op    = OP_DET_CLR;
            cof_nxt   = '0;
            term_nxt  = '0;
            state_nxt = S_RD0;
          end
        end
      end
      S_RD0: begin
        cmd.elem_raddr = factor_pos(cof_r, term_r, 2'd0);
        cmd.op         = (term_r == 3'd0) ? OP_COF_CLR : OP_NONE;
        state_nxt      = S_RD1;
      end
      S_RD1: begin
        cmd.elem_raddr = factor_pos(cof_r, term_r, 2'd1);
        cmd.op         = OP_LD_A;
        state_nxt      = S_RD2;
      end
      S_RD2: begin
        cmd.elem_raddr = factor_pos(cof_r, term_r, 2'd2);
        cmd.op         = OP_LD_B;
        state_nxt      = S_M1;
      end
      S_M1: begin
        cmd.op      = OP_LD_C3;
        cmd.mul_en  = 1'b1;
        cmd.mul_top = 1'b1;
        state_nxt   = S_M1W;
      end
      S_M1W: state_nxt = S_CH;
      S_CH: begin
        cmd.op    = OP_CHAIN;
        state_nxt = S_M2A;
      end
      S_M2A: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_M2B;
      end
      S_M2B: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_limb = 2'd1;
        cmd.mul_top  = 1'b1;
        state_nxt    = S_M2W;
      end
      S_M2W: state_nxt = S_TACC;
      S_TACC: begin
        cmd.op = OP_COF_ACC;
        if (term_r == 3'd5) begin
          state_nxt = S_CEND;
        end else begin
          term_nxt  = term_r + 3'd1;
          state_nxt = S_RD0;
        end
      end
      S_CEND: begin
        cmd.cof_we = 1'b1;
        if (cof_r[1:0] == 2'd0) begin
          // Cofactors of the first column feed the determinant.
          cmd.elem_raddr = {2'b00, cof_r[3:2]};
          state_nxt      = S_DLD;
        end else if (cof_r == LAST_POS) begin
          state_nxt = S_DEN;
        end else begin
          cof_nxt   = cof_r + 4'd1;
          term_nxt  = '0;
          state_nxt = S_RD0;
        end
      end
      S_DLD: begin
        cmd.op    = OP_DET_LD;
        limb_nxt  = '0;
        state_nxt = S_DM;
      end
      S_DM: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_limb = limb_r;
        cmd.mul_top  = (limb_r == 2'd3);
        limb_nxt     = limb_r + 2'd1;
        if (limb_r == 2'd3) begin
          state_nxt = S_DW;
        end
      end
      S_DW: state_nxt = S_DACC;
      S_DACC: begin
        cmd.op    = OP_DET_ACC;
        cof_nxt   = cof_r + 4'd1;
        term_nxt  = '0;
        state_nxt = S_RD0;
      end
      S_DEN: begin
        cmd.op    = OP_DEN;
        cof_nxt   = '0;
        state_nxt = S_QRD;
      end
      S_QRD: begin
        if (status.det_zero) begin
          cmd.op    = OP_RES_SING;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_QNUM;
        end
      end
      S_QNUM: begin
        cmd.op    = OP_NUM;
        state_nxt = S_QINIT;
      end
      S_QINIT: begin
        cmd.op    = OP_DIV_INIT;
        dcnt_nxt  = '0;
        state_nxt = S_QSTEP;
      end
      S_QSTEP: begin
        cmd.op   = OP_DIV_STEP;
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(ELEM_WIDTH - 1)) begin
          state_nxt = S_QRES;
        end
      end
      S_QRES: begin
        cmd.op    = OP_RES;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (cof_r == LAST_POS) begin
            cof_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            cof_nxt   = cof_r + 4'd1;
            state_nxt = S_QRD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cof_r   <= '0;
      term_r  <= '0;
      limb_r  <= '0;
      load_r  <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cof_r   <= cof_nxt;
      term_r  <= term_nxt;
      limb_r  <= limb_nxt;
      load_r  <= load_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/m4inv_dp.sv @@
// Datapath: element and cofactor stores, limb multiplier, accumulators, divider, result register.
`default_nettype none

module m4inv_dp #(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  m4inv_pkg::dp_cmd_t    cmd,
  output m4inv_pkg::dp_status_t status,
  input  logic [31:0]           elem_in,
  output logic [31:0]           result_value,
  output logic [3:0]            result_index,
  output logic                  singular,
  output logic                  last
);

  import m4inv_pkg::*;

  localparam int E    = ELEM_WIDTH;
  localparam int XW   = 4 * E;
  localparam int DW   = 5 * E;
  localparam int CW   = 3 * E + 3;
  localparam int PW   = 2 * E + 2;
  localparam int DENW = 4 * E + 2;
  localparam int NUMW = CW + 2 * FRAC_BITS;
  localparam int GW   = ((NUMW > DENW) ? NUMW : DENW) + 1;
  localparam logic [E-1:0] MAXV    = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] MINV    = {1'b1, {(E-1){1'b0}}};
  localparam logic [E-1:0] ONE_VAL = (FRAC_BITS <= E - 2) ? (E'(1) << FRAC_BITS) : MAXV;

  logic [E-1:0]  elem_rd;
  logic [CW-1:0] cof_rd;

  logic [XW-1:0]        x_r;
  logic [E-1:0]         c_r;
  logic [E-1:0]         e3_r;
  logic signed [PW-1:0] pp_r;
  logic [1:0]           pp_k_r;
  logic                 pp_v_r;
  logic [DW-1:0]        prod_r;
  logic [DW-1:0]        cof_acc_r;
  logic [DW-1:0]        det_r;
  logic [DENW-1:0]      den_r;
  logic                 dneg_r;
  logic                 cneg_r;
  logic [NUMW-1:0]      num_r;
  logic [DENW-1:0]      rem_r;
  logic [E-1:0]         nlo_r;
  logic [E-1:0]         q_r;
  logic                 ovf_r;
  logic [31:0]          val_r;
  logic [3:0]           idx_r;
  logic                 sing_r;
  logic                 last_r;

  m4inv_ram #(.WIDTH(E), .DEPTH(16)) u_elem_ram (
    .clk   (clk),
    .we    (cmd.elem_we),
    .waddr (cmd.elem_waddr),
    .wdata (elem_in[E-1:0]),
    .raddr (cmd.elem_raddr),
    .rdata (elem_rd)
  );

  m4inv_ram #(.WIDTH(CW), .DEPTH(16)) u_cof_ram (
    .clk   (clk),
    .we    (cmd.cof_we),
    .waddr (cmd.cof_addr),
    .wdata (cof_acc_r[CW-1:0]),
    .raddr (cmd.cof_addr),
    .rdata (cof_rd)
  );

  // One limb of the wide operand times the signed element; only the top limb is signed.
  logic [E-1:0]         limb;
  logic signed [E:0]    mul_a;
  logic signed [E:0]    mul_b;
  logic signed [PW-1:0] mul_p;
  logic [DW-1:0]        pp_sh;

  assign limb  = x_r[32'(cmd.mul_limb) * E +: E];
  assign mul_a = {cmd.mul_top & limb[E-1], limb};
  assign mul_b = {c_r[E-1], c_r};
  assign mul_p = mul_a * mul_b;
  assign pp_sh = DW'(pp_r) << (32'(pp_k_r) * E);

  logic [DW-1:0]   det_neg;
  logic [CW-1:0]   cof_mag;
  logic [NUMW-1:0] num_hi;
  logic [DENW:0]   rem2;
  logic [DENW:0]   rem_diff;
  logic            rem_ge;
  logic            res_neg;
  logic [E-1:0]    res_e;

  assign det_neg  = -det_r;
  assign cof_mag  = cof_rd[CW-1] ? -cof_rd : cof_rd;
  assign num_hi   = num_r >> E;
  assign rem2     = {rem_r, nlo_r[E-1]};
  assign rem_ge   = (rem2 >= {1'b0, den_r});
  assign rem_diff = rem2 - {1'b0, den_r};
  assign res_neg  = cneg_r ^ dneg_r;

  always_comb begin
    if (!res_neg) begin
      res_e = (ovf_r || (q_r > MAXV)) ? MAXV : q_r;
    end else begin
      res_e = (ovf_r || (q_r > MINV)) ? MINV : -q_r;
    end
  end

  assign status.det_zero = (det_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_v_r <= 1'b0;
    end else begin
      pp_v_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    pp_r   <= mul_p;
    pp_k_r <= cmd.mul_limb;

    if ((cmd.op == OP_LD_B) || (cmd.op == OP_CHAIN) || (cmd.op == OP_DET_LD)) begin
      prod_r <= '0;
    end else if (pp_v_r) begin
      prod_r <= prod_r + pp_sh;
    end

    unique case (cmd.op)
      OP_NONE: ;
      OP_LD_A:  x_r  <= {{(XW-E){elem_rd[E-1]}}, elem_rd};
      OP_LD_B:  c_r  <= elem_rd;
      OP_LD_C3: e3_r <= elem_rd;
      OP_CHAIN: begin
        x_r <= prod_r[XW-1:0];
        c_r <= e3_r;
      end
      OP_COF_CLR: cof_acc_r <= '0;
      OP_COF_ACC: cof_acc_r <= cmd.term_neg ? cof_acc_r - prod_r : cof_acc_r + prod_r;
      OP_DET_CLR: det_r <= '0;
      OP_DET_LD: begin
        x_r <= cof_acc_r[XW-1:0];
        c_r <= elem_rd;
      end
      OP_DET_ACC: det_r <= det_r + prod_r;
      OP_DEN: begin
        den_r  <= det_r[DW-1] ? det_neg[DENW-1:0] : det_r[DENW-1:0];
        dneg_r <= det_r[DW-1];
      end
      OP_NUM: begin
        cneg_r <= cof_rd[CW-1];
        num_r  <= {cof_mag, {(2 * FRAC_BITS){1'b0}}};
      end
      OP_DIV_INIT: begin
        ovf_r <= (GW'(num_hi) >= GW'(den_r));
        rem_r <= DENW'(num_hi);
        nlo_r <= num_r[E-1:0];
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= rem_ge ? rem_diff[DENW-1:0] : rem2[DENW-1:0];
        q_r   <= {q_r[E-2:0], rem_ge};
        nlo_r <= nlo_r << 1;
      end
      OP_RES: begin
        val_r  <= 32'(signed'(res_e));
        idx_r  <= cmd.cof_addr;
        sing_r <= 1'b0;
        last_r <= (cmd.cof_addr == LAST_POS);
      end
      OP_RES_SING: begin
        val_r  <= (cmd.cof_addr[3:2] == cmd.cof_addr[1:0]) ? 32'(signed'(ONE_VAL)) : '0;
        idx_r  <= cmd.cof_addr;
        sing_r <= 1'b1;
        last_r <= (cmd.cof_addr == LAST_POS);
      end
    endcase
  end

  assign result_value = val_r;
  assign result_index = idx_r;
  assign singular     = sing_r;
  assign last         = last_r;

endmodule

`default_nettype wire

@@ rtl/matrix4_inverse_top.sv @@
// Sequence: the sixteen elements are loaded, then the cofactors and determinant are formed
// (each three-factor term on one shared limb multiplier), then each result word passes
// through the bit-serial divider (skipped when singular), plus output stall.
// One matrix at a time: the next matrix is loaded only after the last result word is taken.
// Reset: synchronous, active low; it clears the controller state and the load count.
// The element and cofactor stores are not cleared; every entry is written before it is read.
`default_nettype none

module matrix4_inverse_top #(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  m4inv_in_if.sink   in_elem,
  m4inv_out_if.source out_res
);

  import m4inv_pkg::*;

  // The controller sequences every step; the datapath holds every value. They share
  // only a command word per cycle and one status flag (determinant is zero).
  dp_cmd_t    cmd;
  dp_status_t status;

  // The input word is taken while the controller waits in its load state. Each
  // accepted word is written to the element store at the current load count. After
  // the sixteenth word the controller walks the 16 cofactors, each as six signed three-factor
  // products, and folds each first-column cofactor into the determinant once it is formed.
  m4inv_ctrl #(.ELEM_WIDTH(ELEM_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_elem.valid),
    .in_ready  (in_elem.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Each result word is the cofactor scaled by 2^(2*FRAC_BITS) and divided by the
  // determinant one quotient bit per cycle, truncated toward zero and saturated.
  // A zero determinant yields the identity matrix with the singular flag set.
  m4inv_dp #(.FRAC_BITS(FRAC_BITS), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .elem_in      (in_elem.element_value),
    .result_value (out_res.result_value),
    .result_index (out_res.result_index),
    .singular     (out_res.singular),
    .last         (out_res.last)
  );

endmodule

`default_nettype wire

@@ rtl/m4inv_checker.sv @@
// Port-level checker for the matrix inverse block and its bind to the top level.
`default_nettype none

module m4inv_assert (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] result_value,
  input wire logic [3:0]  result_index,
  input wire logic        singular,
  input wire logic        last
);

  import m4inv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(result_index))
    else $error("result word changed while stalled");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last == (result_index == LAST_POS)))
    else $error("last marker does not match the final index");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("loading and delivering at the same time");

  a_sing_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && singular && (result_index[3:2] != result_index[1:0]) |->
      result_value == 32'd0)
    else $error("singular result has a nonzero off-diagonal word");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> !out_valid && in_ready)
    else $error("block did not return to loading after the last word");

endmodule

bind matrix4_inverse_top m4inv_assert u_m4inv_assert (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_elem.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .result_value (out_res.result_value),
  .result_index (out_res.result_index),
  .singular     (out_res.singular),
  .last         (out_res.last)
);

`default_nettype wire
